// File: hw/rtl/srt_pkg.sv
// Shared types and constants for the sorted ranking table.
package srt_pkg;

	// Fixed field widths
	localparam int ID_W     = 44;
	localparam int SCORE_W  = 7;
	localparam int GROUP_W  = 7;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 2;

	// Default table depth
	localparam int MAX_ENTRIES_DEF = 1024;

	// Item kinds
	localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

	// One table entry
	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [SCORE_W-1:0] score;
		logic [GROUP_W-1:0] group;
	} entry_t;

	// Commands broadcast from the controller to every cell
	typedef struct packed {
		logic insert;
		logic tap_load;
		logic tap_shift;
	} cell_cmd_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOCATE,
		ST_COUNT,
		ST_DONE
	} state_t;

endpackage

// File: hw/rtl/srt_cell.sv
// One cell of the sorted chain: holds one entry and one read tap.
module srt_cell #(
	parameter int INDEX = 0,
	parameter int CNT_W = 11
) (
	input  logic              clk,
	input  srt_pkg::cell_cmd_t cmd,
	input  logic [CNT_W-1:0]  count,
	input  srt_pkg::entry_t   new_ent,
	input  srt_pkg::entry_t   left_ent,
	input  logic              left_ge,
	output logic              ge,
	output srt_pkg::entry_t   ent,
	input  srt_pkg::entry_t   tap_in,
	output srt_pkg::entry_t   tap_out
);

	localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

	srt_pkg::entry_t ent_q;
	srt_pkg::entry_t tap_q;
	logic            live;
	logic            at_end;
	logic            ahead;

	// New entry sorts ahead of this cell's entry, or this cell is the first free slot
	always_comb begin
		live   = IDX < count;
		at_end = IDX == count;
		ahead  = (new_ent.score > ent_q.score) ||
			((new_ent.score == ent_q.score) && (new_ent.id < ent_q.id));
		ge     = (live && ahead) || at_end;
	end

	// Insert: take the neighbor's entry when the slot moves down, else the new one
	always_ff @(posedge clk) begin
		if (cmd.insert && ge) begin
			if (left_ge) begin
				ent_q <= left_ent;
			end else begin
				ent_q <= new_ent;
			end
		end
	end

	// Read tap: snapshot of the entry, shifted toward cell 0 one step a cycle while a shift is commanded
	always_ff @(posedge clk) begin
		if (cmd.tap_load) begin
			tap_q <= ent_q;
		end else if (cmd.tap_shift) begin
			tap_q <= tap_in;
		end
	end

	assign ent     = ent_q;
	assign tap_out = tap_q;

endmodule

// File: hw/rtl/srt_ctrl.sv
// Controller: handshakes, entry count, read scan and result register.
module srt_ctrl #(
	parameter int MAX_ENTRIES = srt_pkg::MAX_ENTRIES_DEF,
	parameter int CNT_W       = $clog2(MAX_ENTRIES + 1),
	parameter int POS_W       = $clog2(MAX_ENTRIES)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic [srt_pkg::KIND_W-1:0]   kind,
	input  logic [POS_W-1:0]             position,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic [srt_pkg::STATUS_W-1:0] status,
	output logic [srt_pkg::ID_W-1:0]     out_id,
	output logic [CNT_W-1:0]             overall_rank,
	output logic [srt_pkg::GROUP_W-1:0]  out_group,
	output logic [CNT_W-1:0]             group_rank,
	output logic [CNT_W-1:0]             entry_count,
	output srt_pkg::cell_cmd_t           cmd,
	output logic [CNT_W-1:0]             count,
	input  srt_pkg::entry_t              head_ent
);

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

	srt_pkg::state_t state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic             result_valid_q;
	logic             full;
	logic             pos_ok;
	logic             out_take;
	logic             at_pos;

	logic [POS_W-1:0]             pos_q;
	logic [POS_W-1:0]             idx_q;
	logic [srt_pkg::SCORE_W-1:0]  tgt_score_q;
	logic [CNT_W-1:0]             above_q;
	logic [CNT_W-1:0]             above_grp_q;
	logic [srt_pkg::STATUS_W-1:0] res_status_q;
	logic [srt_pkg::ID_W-1:0]     res_id_q;
	logic [CNT_W-1:0]             res_orank_q;
	logic [srt_pkg::GROUP_W-1:0]  res_group_q;
	logic [CNT_W-1:0]             res_grank_q;
	logic [srt_pkg::STATUS_W-1:0] out_status_q;
	logic [srt_pkg::ID_W-1:0]     out_id_q;
	logic [CNT_W-1:0]             out_orank_q;
	logic [srt_pkg::GROUP_W-1:0]  out_group_q;
	logic [CNT_W-1:0]             out_grank_q;
	logic [CNT_W-1:0]             out_count_q;

	assign full     = count_q == MAX_CNT;
	assign pos_ok   = CNT_W'(position) < count_q;
	assign out_take = !result_valid_q || !result_stall;
	assign at_pos   = idx_q == pos_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and cell commands
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_stall = state_q != srt_pkg::ST_IDLE;
		case (state_q)
			srt_pkg::ST_IDLE: begin
				if (item_valid) begin
					state_d = srt_pkg::ST_DONE;
					case (kind)
						srt_pkg::KIND_ADD: begin
							cmd.insert = !full;
						end
						srt_pkg::KIND_READ: begin
							if (pos_ok) begin
								cmd.tap_load = 1'b1;
								state_d      = srt_pkg::ST_LOCATE;
							end
						end
						default: begin
						end
					endcase
				end
			end
			srt_pkg::ST_LOCATE: begin
				if (at_pos) begin
					cmd.tap_load = 1'b1;
					state_d      = srt_pkg::ST_COUNT;
				end else begin
					cmd.tap_shift = 1'b1;
				end
			end
			srt_pkg::ST_COUNT: begin
				if (at_pos) begin
					state_d = srt_pkg::ST_DONE;
				end else begin
					cmd.tap_shift = 1'b1;
				end
			end
			srt_pkg::ST_DONE: begin
				if (out_take) begin
					state_d = srt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = srt_pkg::ST_IDLE;
			end
		endcase
	end

	// Entry count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (state_q == srt_pkg::ST_IDLE && item_valid) begin
				if (kind == srt_pkg::KIND_ADD && !full) begin
					count_q <= count_q + CNT_W'(1);
				end else if (kind == srt_pkg::KIND_CLEAR) begin
					count_q <= '0;
				end
			end
			if (state_q == srt_pkg::ST_DONE && out_take) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Read scan: first pass finds the entry, second pass counts higher scores
	always_ff @(posedge clk) begin
		case (state_q)
			srt_pkg::ST_IDLE: begin
				pos_q        <= position;
				idx_q        <= '0;
				above_q      <= '0;
				above_grp_q  <= '0;
				res_id_q     <= '0;
				res_orank_q  <= '0;
				res_group_q  <= '0;
				res_grank_q  <= '0;
				res_status_q <= srt_pkg::STATUS_OK;
				if (kind == srt_pkg::KIND_ADD && full) begin
					res_status_q <= srt_pkg::STATUS_FULL;
				end else if (kind == srt_pkg::KIND_READ && !pos_ok) begin
					res_status_q <= srt_pkg::STATUS_RANGE;
				end
			end
			srt_pkg::ST_LOCATE: begin
				if (at_pos) begin
					tgt_score_q <= head_ent.score;
					res_id_q    <= head_ent.id;
					res_group_q <= head_ent.group;
					idx_q       <= '0;
				end else begin
					idx_q <= idx_q + POS_W'(1);
				end
			end
			srt_pkg::ST_COUNT: begin
				if (at_pos) begin
					res_orank_q <= above_q + CNT_W'(1);
					res_grank_q <= above_grp_q + CNT_W'(1);
				end else begin
					idx_q <= idx_q + POS_W'(1);
					if (head_ent.score > tgt_score_q) begin
						above_q <= above_q + CNT_W'(1);
						if (head_ent.group == res_group_q) begin
							above_grp_q <= above_grp_q + CNT_W'(1);
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Output register; the count is captured with the beat so it holds while stalled
	always_ff @(posedge clk) begin
		if (state_q == srt_pkg::ST_DONE && out_take) begin
			out_status_q <= res_status_q;
			out_id_q     <= res_id_q;
			out_orank_q  <= res_orank_q;
			out_group_q  <= res_group_q;
			out_grank_q  <= res_grank_q;
			out_count_q  <= count_q;
		end
	end

	assign result_valid = result_valid_q;
	assign status       = out_status_q;
	assign out_id       = out_id_q;
	assign overall_rank = out_orank_q;
	assign out_group    = out_group_q;
	assign group_rank   = out_grank_q;
	assign entry_count  = out_count_q;
	assign count        = count_q;

`ifndef ASSERT_OFF
	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |-> count_q < MAX_CNT)
		else $error("insert issued on a full table");
	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("entry count did not follow an insert");
	a_tap_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.tap_load && cmd.tap_shift) && !(cmd.insert && cmd.tap_shift))
		else $error("conflicting cell commands");
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> item_stall)
		else $error("item taken without going busy");
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == srt_pkg::ST_COUNT || state_q == srt_pkg::ST_LOCATE) |-> idx_q <= pos_q)
		else $error("scan index passed the read position");
`endif

endmodule

// File: hw/rtl/sorted_ranking_table_top.sv
// Top level of the sorted ranking table: cell chain plus controller.
//
// The table is a chain of MAX_ENTRIES cells kept sorted by descending score,
// ties by ascending identifier. An add, a clear, an unused kind or a rejected
// item (full table, position not below the count) goes from accepted beat
// straight to result: every cell compares the new entry in parallel and
// all shift together. A successful read of sorted position p scans twice:
// the read taps of the cells shift toward cell 0 one entry a cycle, once to
// find the entry and once more to count the entries with a higher score,
// overall and in its group. One item is in work at a time; the result sits
// in an output register, so a new item is taken while the last result
// waits. Ranks are competition ranks (1 + number of strictly higher scores).
module sorted_ranking_table_top #(
	parameter int MAX_ENTRIES = srt_pkg::MAX_ENTRIES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic [srt_pkg::KIND_W-1:0]          kind,
	input  logic [srt_pkg::ID_W-1:0]            entry_id,
	input  logic [srt_pkg::SCORE_W-1:0]         score,
	input  logic [srt_pkg::GROUP_W-1:0]         group,
	input  logic [$clog2(MAX_ENTRIES)-1:0]      position,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [srt_pkg::STATUS_W-1:0]        status,
	output logic [srt_pkg::ID_W-1:0]            out_id,
	output logic [$clog2(MAX_ENTRIES + 1)-1:0]  overall_rank,
	output logic [srt_pkg::GROUP_W-1:0]         out_group,
	output logic [$clog2(MAX_ENTRIES + 1)-1:0]  group_rank,
	output logic [$clog2(MAX_ENTRIES + 1)-1:0]  entry_count
);

	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int POS_W = $clog2(MAX_ENTRIES);

	srt_pkg::cell_cmd_t cmd;
	srt_pkg::entry_t    new_ent;
	logic [CNT_W-1:0]   count;
	srt_pkg::entry_t    ent [MAX_ENTRIES];
	srt_pkg::entry_t    tap [MAX_ENTRIES];
	logic               ge  [MAX_ENTRIES];

	assign new_ent.id    = entry_id;
	assign new_ent.score = score;
	assign new_ent.group = group;

	// Cell chain
	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		srt_pkg::entry_t left_ent;
		srt_pkg::entry_t tap_in;
		logic            left_ge;

		if (i == 0) begin : g_first
			assign left_ent = '0;
			assign left_ge  = 1'b0;
		end else begin : g_next
			assign left_ent = ent[i-1];
			assign left_ge  = ge[i-1];
		end

		if (i == MAX_ENTRIES - 1) begin : g_last
			assign tap_in = '0;
		end else begin : g_inner
			assign tap_in = tap[i+1];
		end

		srt_cell #(
			.INDEX (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.count    (count),
			.new_ent  (new_ent),
			.left_ent (left_ent),
			.left_ge  (left_ge),
			.ge       (ge[i]),
			.ent      (ent[i]),
			.tap_in   (tap_in),
			.tap_out  (tap[i])
		);
	end

	// Controller
	srt_ctrl #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.CNT_W       (CNT_W),
		.POS_W       (POS_W)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.kind         (kind),
		.position     (position),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.out_id       (out_id),
		.overall_rank (overall_rank),
		.out_group    (out_group),
		.group_rank   (group_rank),
		.entry_count  (entry_count),
		.cmd          (cmd),
		.count        (count),
		.head_ent     (tap[0])
	);

endmodule
